// ===== rtl/srs_pkg.sv =====
// Shared constants, state encoding and control structs for the step record statistics block.
package srs_pkg;

    localparam int MAX_RECORDS = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int SUM_W       = SAMPLE_BITS + IDX_W;
    localparam int STEP_W      = $clog2(SUM_W);
    localparam int THR_W       = 16;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(500);
    localparam int RES_BITS    = CNT_W + 4 * IDX_W + SAMPLE_BITS;
    localparam int OUT_DATA_W  = ((RES_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DIVIDE,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic take;
        logic div_start;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/srs_div.sv =====
// Restoring divider for the mean: one quotient bit per cycle.
module srs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [srs_pkg::SUM_W-1:0]  i_dividend,
    input  logic [srs_pkg::CNT_W-1:0]  i_divisor,
    output logic                       o_busy,
    output logic [srs_pkg::SUM_W-1:0]  o_quotient
);
    import srs_pkg::*;

    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;

    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    diff;
    logic              ge;

    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_div};
    assign diff   = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_step == STEP_W'(SUM_W - 1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_step <= '0;
        end else if (r_busy) begin
            // shift in one quotient bit, keep the partial remainder below the divisor
            r_quo  <= {r_quo[SUM_W-2:0], ge};
            r_rem  <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            r_step <= r_step + STEP_W'(1);
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/srs_datapath.sv =====
// Accumulators for count, extremes, sum and longest run, threshold register, result snapshot and output register.
module srs_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  srs_pkg::t_cmd                   i_cmd,
    output srs_pkg::t_status                o_status,
    input  logic [srs_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                            i_last,
    input  logic                            i_cfg_wr_en,
    input  logic [srs_pkg::THR_W-1:0]       i_cfg_wr_data,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [srs_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic                            o_m_tuser
);
    import srs_pkg::*;

    logic [THR_W-1:0]       r_thr;
    logic [CNT_W-1:0]       r_count,      n_count;
    logic [SAMPLE_BITS-1:0] r_min,        n_min;
    logic [IDX_W-1:0]       r_min_pos,    n_min_pos;
    logic [SAMPLE_BITS-1:0] r_max,        n_max;
    logic [IDX_W-1:0]       r_max_pos,    n_max_pos;
    logic [SUM_W-1:0]       r_sum,        n_sum;
    logic                   r_in_run,     n_in_run;
    logic [IDX_W-1:0]       r_cur_start,  n_cur_start;
    logic [IDX_W-1:0]       r_best_start, n_best_start;
    logic [IDX_W-1:0]       r_best_end,   n_best_end;
    logic                   r_best_valid, n_best_valid;

    logic [CNT_W-1:0]       r_res_count;
    logic [IDX_W-1:0]       r_res_min_pos;
    logic [IDX_W-1:0]       r_res_max_pos;
    logic                   r_res_found;
    logic [IDX_W-1:0]       r_res_start;
    logic [IDX_W-1:0]       r_res_end;

    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;
    logic                   r_out_user;

    logic [IDX_W-1:0]       idx;
    logic [IDX_W-1:0]       cand_start;
    logic [IDX_W-1:0]       run_len;
    logic [IDX_W-1:0]       best_len;
    logic                   room;
    logic                   above;
    logic                   div_busy;
    logic [SUM_W-1:0]       quotient;

    srs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_count),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    assign idx        = r_count[IDX_W-1:0];
    assign room       = r_count < CNT_W'(MAX_RECORDS);
    assign above      = i_sample > r_thr;
    assign cand_start = r_in_run ? r_cur_start : idx;
    assign run_len    = idx - cand_start;
    assign best_len   = r_best_end - r_best_start;

    always_comb begin
        n_count      = r_count;
        n_min        = r_min;
        n_min_pos    = r_min_pos;
        n_max        = r_max;
        n_max_pos    = r_max_pos;
        n_sum        = r_sum;
        n_in_run     = r_in_run;
        n_cur_start  = r_cur_start;
        n_best_start = r_best_start;
        n_best_end   = r_best_end;
        n_best_valid = r_best_valid;
        // past capacity a sample changes nothing
        if (room) begin
            if (r_count == '0) begin
                n_min     = i_sample;
                n_min_pos = '0;
                n_max     = i_sample;
                n_max_pos = '0;
            end else begin
                if (i_sample < r_min) begin
                    n_min     = i_sample;
                    n_min_pos = idx;
                end
                if (i_sample > r_max) begin
                    n_max     = i_sample;
                    n_max_pos = idx;
                end
            end
            n_sum = r_sum + SUM_W'(i_sample);
            if (above) begin
                n_in_run    = 1'b1;
                n_cur_start = cand_start;
                // only a strictly longer run replaces the best one
                if (!r_best_valid || run_len > best_len) begin
                    n_best_start = cand_start;
                    n_best_end   = idx;
                    n_best_valid = 1'b1;
                end
            end else begin
                n_in_run = 1'b0;
            end
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_sum        <= '0;
            r_in_run     <= 1'b0;
            r_best_valid <= 1'b0;
        end else if (i_cmd.take) begin
            if (i_last) begin
                r_count      <= '0;
                r_sum        <= '0;
                r_in_run     <= 1'b0;
                r_best_valid <= 1'b0;
            end else begin
                r_count      <= n_count;
                r_sum        <= n_sum;
                r_in_run     <= n_in_run;
                r_best_valid <= n_best_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_min        <= n_min;
            r_min_pos    <= n_min_pos;
            r_max        <= n_max;
            r_max_pos    <= n_max_pos;
            r_cur_start  <= n_cur_start;
            r_best_start <= n_best_start;
            r_best_end   <= n_best_end;
        end
    end

    // hold the finished set's figures while the mean is divided
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_last) begin
            r_res_count   <= n_count;
            r_res_min_pos <= n_min_pos;
            r_res_max_pos <= n_max_pos;
            r_res_found   <= n_best_valid;
            r_res_start   <= n_best_valid ? n_best_start : '0;
            r_res_end     <= n_best_valid ? n_best_end : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= OUT_DATA_W'({r_res_end, r_res_start,
                                       quotient[SAMPLE_BITS-1:0],
                                       r_res_max_pos, r_res_min_pos, r_res_count});
            r_out_user <= r_res_found;
        end
    end

    assign o_status.div_busy = div_busy;
    assign o_status.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid        = r_out_valid;
    assign o_m_tdata         = r_out_data;
    assign o_m_tuser         = r_out_user;

endmodule

// ===== rtl/srs_ctrl.sv =====
// Controller: accumulate samples, run the mean division, hand the result to the output register.
module srs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tlast,
    output logic               o_s_tready,
    input  srs_pkg::t_status   i_status,
    output srs_pkg::t_cmd      o_cmd
);
    import srs_pkg::*;

    t_state r_state, n_state;
    logic   take;

    assign take = i_s_tvalid && (r_state == ST_ACCUM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCUM;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_ACCUM: begin
                if (take && i_s_tlast) begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (!i_status.div_busy) begin
                    n_state = i_status.out_free ? ST_ACCUM : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (i_status.out_free) begin
                    n_state = ST_ACCUM;
                end
            end
            default: n_state = ST_ACCUM;
        endcase
    end

    always_comb begin
        o_s_tready      = 1'b0;
        o_cmd.take      = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.load_out  = 1'b0;
        unique case (r_state)
            ST_ACCUM: begin
                o_s_tready      = 1'b1;
                o_cmd.take      = take;
                o_cmd.div_start = take && i_s_tlast;
            end
            ST_DIVIDE: begin
                o_cmd.load_out = !i_status.div_busy && i_status.out_free;
            end
            ST_HOLD: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/step_record_statistics.sv =====
// Top level of the step record statistics block.
//
// Input stream: one step sample per item in s_tdata, s_tlast marks the last
// sample of a data set. Samples are taken one per cycle while the block is
// accumulating. Samples past the capacity of 1024 are dropped, but a dropped
// sample carrying tlast still closes the set.
// Output stream: one item per data set with record count, first minimum and
// maximum index, truncated mean and the longest run above the threshold;
// m_tuser says whether any run was found (run indices are zero otherwise).
// After the last sample is taken the mean is formed by a restoring
// divider at one quotient bit per cycle; s_tready stays low until the
// result is loaded into the output register.
// If the receiver stalls, the result waits in the output register while the
// next set accumulates; a second set end waits until that register empties.
// The threshold register is written with cfg_wr_en; the user must write it
// only while the block is idle, the block itself does not enforce this.
// Reset (synchronous, active low) sets the threshold to 500, clears the
// count and sum accumulators and the run state and drops any pending result.
module step_record_statistics (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [srs_pkg::THR_W-1:0]       i_cfg_wr_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // step_sample
    input  logic [srs_pkg::SAMPLE_BITS-1:0] i_s_tdata,
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // record_count, fewest_index, largest_index, mean_steps,
    // run_start_index, run_end_index, zero padding
    output logic [srs_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // run_found
    output logic                            o_m_tuser
);
    import srs_pkg::*;

    t_cmd    cmd;
    t_status status;

    srs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    srs_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_sample      (i_s_tdata),
        .i_last        (i_s_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

endmodule

// ===== verif/tb.sv =====
// Testbench for step_record_statistics: streams data sets, predicts each summary and checks it.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int CNT_LSB = 0;
    localparam int LO_LSB = CNT_W;
    localparam int HI_LSB = LO_LSB + IDX_W;
    localparam int MEAN_LSB = HI_LSB + IDX_W;
    localparam int RS_LSB = MEAN_LSB + SAMPLE_BITS;
    localparam int RE_LSB = RS_LSB + IDX_W;

    typedef struct {
        logic [CNT_W-1:0]       count;
        logic [IDX_W-1:0]       lo_idx;
        logic [IDX_W-1:0]       hi_idx;
        logic [SAMPLE_BITS-1:0] mean;
        logic                   found;
        logic [IDX_W-1:0]       run_from;
        logic [IDX_W-1:0]       run_to;
    } t_summary;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [THR_W-1:0]        i_cfg_wr_data = '0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    logic [SAMPLE_BITS-1:0]  i_s_tdata = '0;
    logic                    i_s_tlast = 1'b0;
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   o_m_tdata;
    logic                    o_m_tuser;

    step_record_statistics dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor copy of the block state
    int          thr_now = 500;
    int          seen_cnt;
    int          lo_val, lo_pos, hi_val, hi_pos;
    longint      step_sum;
    bit          in_run;
    int          run_begin, best_from, best_to;
    bit          best_ok;

    t_summary    summary_q[$];
    int          mismatches = 0;
    int          summaries_checked = 0;
    int          samples_sent = 0;
    int          cycles = 0;
    bit          src_idle_en = 1'b1;
    bit          snk_idle_en = 1'b1;

    task automatic clear_set_stats();
        seen_cnt = 0;
        lo_val = 0;
        lo_pos = 0;
        hi_val = 0;
        hi_pos = 0;
        step_sum = 0;
        in_run = 1'b0;
        run_begin = 0;
        best_from = 0;
        best_to = 0;
        best_ok = 1'b0;
    endtask

    task automatic fold_sample(input int smp, input bit lst);
        t_summary s;
        int       idx;
        idx = seen_cnt;
        if (seen_cnt < MAX_RECORDS) begin
            if (idx == 0) begin
                lo_val = smp;
                lo_pos = 0;
                hi_val = smp;
                hi_pos = 0;
            end else begin
                if (smp < lo_val) begin
                    lo_val = smp;
                    lo_pos = idx;
                end
                if (smp > hi_val) begin
                    hi_val = smp;
                    hi_pos = idx;
                end
            end
            step_sum += smp;
            if (smp > thr_now) begin
                if (!in_run) begin
                    in_run = 1'b1;
                    run_begin = idx;
                end
                // strictly longer only, so the first of equal runs stays
                if (!best_ok || (idx - run_begin) > (best_to - best_from)) begin
                    best_from = run_begin;
                    best_to = idx;
                    best_ok = 1'b1;
                end
            end else begin
                in_run = 1'b0;
            end
            seen_cnt = idx + 1;
        end
        if (lst) begin
            s.count = CNT_W'(seen_cnt);
            s.lo_idx = IDX_W'(lo_pos);
            s.hi_idx = IDX_W'(hi_pos);
            s.mean = SAMPLE_BITS'(step_sum / seen_cnt);
            s.found = best_ok;
            s.run_from = best_ok ? IDX_W'(best_from) : '0;
            s.run_to = best_ok ? IDX_W'(best_to) : '0;
            summary_q.push_back(s);
            clear_set_stats();
        end
    endtask

    task automatic send_sample(input int smp, input bit lst);
        if (src_idle_en) begin
            while ($urandom_range(99) < 34) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= SAMPLE_BITS'(smp);
        i_s_tlast <= lst;
        do @(posedge i_clk); while (!o_s_tready);
        fold_sample(smp, lst);
        samples_sent++;
    endtask

    // drop valid and let the block empty before touching the threshold
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (summary_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_threshold(input int value);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= THR_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        thr_now = value;
    endtask

    function automatic int pick_sample(input int mode, input int above_pct);
        int v;
        case (mode)
            0: v = $urandom_range(65535);
            1: begin
                if ($urandom_range(99) < above_pct && thr_now < 65535)
                    v = $urandom_range(65535, thr_now + 1);
                else
                    v = $urandom_range(thr_now, 0);
            end
            default: begin
                // hover around the threshold to force ties and boundary compares
                v = thr_now + $urandom_range(2) - 1;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
            end
        endcase
        return v;
    endfunction

    task automatic send_random_sets(input int n_items);
        int goal, len, mode, above_pct;
        goal = samples_sent + n_items;
        while (samples_sent < goal) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(200, 40) : $urandom_range(24, 1);
            if (len > goal - samples_sent)
                len = goal - samples_sent;
            mode = $urandom_range(2);
            above_pct = $urandom_range(100);
            for (int k = 0; k < len; k++)
                send_sample(pick_sample(mode, above_pct), k == len - 1);
        end
    endtask

    task automatic test_directed_cases();
        // single samples at both extremes; the top one is a one-sample run
        send_sample(0, 1'b1);
        send_sample(65535, 1'b1);
        // two runs of equal length, tied minimum and maximum
        send_sample(600, 1'b0);
        send_sample(600, 1'b0);
        send_sample(10, 1'b0);
        send_sample(700, 1'b0);
        send_sample(700, 1'b0);
        send_sample(10, 1'b1);
        // samples equal to the threshold do not extend a run
        send_sample(500, 1'b0);
        send_sample(500, 1'b0);
        send_sample(501, 1'b0);
        send_sample(500, 1'b1);
        // a longer later run replaces the earlier one
        send_sample(900, 1'b0);
        send_sample(10, 1'b0);
        send_sample(900, 1'b0);
        send_sample(900, 1'b1);
        drain();
    endtask

    task automatic test_capacity();
        // overfull set: one long run ending at the largest sample, smallest at the
        // final kept index, then dropped samples with the closing one among them
        for (int k = 0; k < MAX_RECORDS + 3; k++) begin
            if (k == MAX_RECORDS - 2)
                send_sample(65535, 1'b0);
            else if (k == MAX_RECORDS - 1)
                send_sample(0, 1'b0);
            else if (k < MAX_RECORDS)
                send_sample($urandom_range(60000, 1000), 1'b0);
            else
                send_sample((k % 2) ? 0 : 65535, k == MAX_RECORDS + 2);
        end
        drain();
    endtask

    task automatic test_threshold_sweep();
        set_threshold(0);
        send_random_sets(30);
        set_threshold(65535);
        send_random_sets(30);
        set_threshold(1);
        send_random_sets(30);
        set_threshold(65534);
        send_random_sets(30);
        set_threshold($urandom_range(65535));
        send_random_sets(30);
        drain();
    endtask

    task automatic test_random_sets();
        set_threshold(500);
        send_random_sets(40);
        // hold both sides busy for a stretch
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        send_random_sets(40);
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        set_threshold($urandom_range(4000));
        send_random_sets(30);
        drain();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= snk_idle_en ? ($urandom_range(99) >= 34) : 1'b1;
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in summary %0d field %s: expected %0d, got %0d",
                         summaries_checked, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_summary s;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (summary_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected summary item: tdata %h tuser %b", o_m_tdata, o_m_tuser);
            end else begin
                s = summary_q.pop_front();
                check_field("record_count", s.count, o_m_tdata[CNT_LSB +: CNT_W]);
                check_field("fewest_index", s.lo_idx, o_m_tdata[LO_LSB +: IDX_W]);
                check_field("largest_index", s.hi_idx, o_m_tdata[HI_LSB +: IDX_W]);
                check_field("mean_steps", s.mean, o_m_tdata[MEAN_LSB +: SAMPLE_BITS]);
                check_field("run_found", s.found, o_m_tuser);
                check_field("run_start_index", s.run_from, o_m_tdata[RS_LSB +: IDX_W]);
                check_field("run_end_index", s.run_to, o_m_tdata[RE_LSB +: IDX_W]);
                summaries_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d summaries outstanding",
                     cycles, summary_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        clear_set_stats();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_capacity();
        test_threshold_sweep();
        test_random_sets();
        if (summary_q.size() != 0) begin
            mismatches += summary_q.size();
            $display("%0d summaries never arrived", summary_q.size());
        end
        $display("covered %0d samples in %0d data sets over thresholds 0, 1, 500, 65534, 65535",
                 samples_sent, summaries_checked);
        $display("and random ones, including an overfull set; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/srs_pkg.sv
rtl/srs_div.sv
rtl/srs_datapath.sv
rtl/srs_ctrl.sv
rtl/step_record_statistics.sv
verif/tb.sv
